// File: hdl/tcf_pkg.sv
// ----------------------------------------------------------------------------
// tcf_pkg
// Shared constants, codes and types of the two-class oldest-first queue.
// ----------------------------------------------------------------------------
package tcf_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int DEPTH_W     = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int STAMP_W     = 32;
    localparam int PID_W       = 32;
    localparam int ENTRY_W     = STAMP_W + PID_W;

    // command codes
    localparam logic [1:0] CMD_ENQ     = 2'd0;
    localparam logic [1:0] CMD_DEQ_ANY = 2'd1;
    localparam logic [1:0] CMD_DEQ_C1  = 2'd2;
    localparam logic [1:0] CMD_DEQ_C0  = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic capture;   // latch the word and read both queue heads
        logic exec;      // update the queues and load the result
    } t_dp_cmd;

endpackage

// File: hdl/tcf_ctrl.sv
// ----------------------------------------------------------------------------
// tcf_ctrl
// Sequencer: accepts a word, runs the execute state, holds the result valid.
// ----------------------------------------------------------------------------
module tcf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_ready,
    output tcf_pkg::t_dp_cmd o_cmd
);
    import tcf_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;

    // output register is free now or is being emptied this cycle
    assign o_ready  = (r_state == S_IDLE) && (!r_out_valid || i_ready);
    assign w_accept = i_valid && o_ready;
    assign o_valid  = r_out_valid;

    assign o_cmd.capture = w_accept;
    assign o_cmd.exec    = (r_state == S_EXEC);

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == S_EXEC)
        else $error("accepted word did not enter execute");

    a_exec_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EXEC |-> !r_out_valid)
        else $error("execute with result register still occupied");

    a_exec_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EXEC |=> r_out_valid && r_state == S_IDLE)
        else $error("execute did not produce a result");

endmodule

// File: hdl/tcf_dpath.sv
// ----------------------------------------------------------------------------
// tcf_dpath
// Two ring buffers with head/tail/count, arrival stamp counter, head
// stamp compare and the result register.
// ----------------------------------------------------------------------------
module tcf_dpath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  tcf_pkg::t_dp_cmd          i_cmd,
    input  logic [1:0]                i_cmd_code,
    input  logic                      i_item_class,
    input  logic [tcf_pkg::PID_W-1:0] i_pet_id,
    output logic [1:0]                o_status,
    output logic [tcf_pkg::PID_W-1:0] o_out_pet_id,
    output logic                      o_out_class
);
    import tcf_pkg::*;

    // queue storage, stamp in the upper half
    logic [ENTRY_W-1:0] r_mem0 [QUEUE_DEPTH];
    logic [ENTRY_W-1:0] r_mem1 [QUEUE_DEPTH];
    logic [ENTRY_W-1:0] r_rd0, r_rd1;

    logic [DEPTH_W-1:0] r_head0, r_head1, r_tail0, r_tail1;
    logic [CNT_W-1:0]   r_cnt0, r_cnt1;
    logic [STAMP_W-1:0] r_stamp;

    // latched word
    logic [1:0]         r_code;
    logic               r_cls;
    logic [PID_W-1:0]   r_pid;

    logic [1:0]         r_status;
    logic [PID_W-1:0]   r_out_pid;
    logic               r_out_cls;

    logic w_nz0, w_nz1, w_full0, w_full1;
    logic w_push0, w_push1, w_pop0, w_pop1;
    logic [1:0] w_status;

    function automatic logic [DEPTH_W-1:0] ring_next(input logic [DEPTH_W-1:0] idx);
        if (idx == DEPTH_W'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return idx + 1'b1;
    endfunction

    assign w_nz0   = (r_cnt0 != '0);
    assign w_nz1   = (r_cnt1 != '0);
    assign w_full0 = (r_cnt0 == CNT_W'(QUEUE_DEPTH));
    assign w_full1 = (r_cnt1 == CNT_W'(QUEUE_DEPTH));

    always_comb begin
        w_push0  = 1'b0;
        w_push1  = 1'b0;
        w_pop0   = 1'b0;
        w_pop1   = 1'b0;
        w_status = ST_OK;
        case (r_code)
            CMD_ENQ: begin
                if (r_cls) begin
                    w_push1  = !w_full1;
                    w_status = w_full1 ? ST_FULL : ST_OK;
                end else begin
                    w_push0  = !w_full0;
                    w_status = w_full0 ? ST_FULL : ST_OK;
                end
            end
            CMD_DEQ_ANY: begin
                if (w_nz1 && w_nz0) begin
                    // class 1 wins ties
                    if (r_rd1[ENTRY_W-1:PID_W] <= r_rd0[ENTRY_W-1:PID_W]) begin
                        w_pop1 = 1'b1;
                    end else begin
                        w_pop0 = 1'b1;
                    end
                end else if (w_nz1) begin
                    w_pop1 = 1'b1;
                end else if (w_nz0) begin
                    w_pop0 = 1'b1;
                end else begin
                    w_status = ST_EMPTY;
                end
            end
            CMD_DEQ_C1: begin
                w_pop1   = w_nz1;
                w_status = w_nz1 ? ST_OK : ST_EMPTY;
            end
            default: begin
                w_pop0   = w_nz0;
                w_status = w_nz0 ? ST_OK : ST_EMPTY;
            end
        endcase
    end

    // storage and head reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_rd0 <= r_mem0[r_head0];
            r_rd1 <= r_mem1[r_head1];
        end
        if (i_cmd.exec && w_push0) begin
            r_mem0[r_tail0] <= {r_stamp, r_pid};
        end
        if (i_cmd.exec && w_push1) begin
            r_mem1[r_tail1] <= {r_stamp, r_pid};
        end
    end

    // word latch and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_code <= i_cmd_code;
            r_cls  <= i_item_class;
            r_pid  <= i_pet_id;
        end
        if (i_cmd.exec) begin
            r_status <= w_status;
            if (w_pop1) begin
                r_out_pid <= r_rd1[PID_W-1:0];
                r_out_cls <= 1'b1;
            end else if (w_pop0) begin
                r_out_pid <= r_rd0[PID_W-1:0];
                r_out_cls <= 1'b0;
            end else begin
                r_out_pid <= '0;
                r_out_cls <= 1'b0;
            end
        end
    end

    // queue pointers and stamp counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head0 <= '0;
            r_head1 <= '0;
            r_tail0 <= '0;
            r_tail1 <= '0;
            r_cnt0  <= '0;
            r_cnt1  <= '0;
            r_stamp <= '0;
        end else if (i_cmd.exec) begin
            if (w_push0) begin
                r_tail0 <= ring_next(r_tail0);
                r_cnt0  <= r_cnt0 + 1'b1;
            end
            if (w_push1) begin
                r_tail1 <= ring_next(r_tail1);
                r_cnt1  <= r_cnt1 + 1'b1;
            end
            if (w_pop0) begin
                r_head0 <= ring_next(r_head0);
                r_cnt0  <= r_cnt0 - 1'b1;
            end
            if (w_pop1) begin
                r_head1 <= ring_next(r_head1);
                r_cnt1  <= r_cnt1 - 1'b1;
            end
            if (w_push0 || w_push1) begin
                r_stamp <= r_stamp + 1'b1;
            end
        end
    end

    assign o_status     = r_status;
    assign o_out_pet_id = r_out_pid;
    assign o_out_class  = r_out_cls;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt0 <= CNT_W'(QUEUE_DEPTH) && r_cnt1 <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_single_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |-> $countones({w_push0, w_push1, w_pop0, w_pop1}) <= 1)
        else $error("more than one queue update in one command");

    a_stamp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.exec && (w_push0 || w_push1)) |=> $stable(r_stamp))
        else $error("stamp moved without an enqueue");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && w_push0 |=> r_cnt0 == $past(r_cnt0) + 1'b1)
        else $error("class 0 count not advanced on enqueue");

endmodule

// File: hdl/two_class_fifo_oldest_first.sv
// ----------------------------------------------------------------------------
// two_class_fifo_oldest_first
// Two bounded class queues with stamped entries and oldest-first dequeue.
//
//   channel  direction  handshake           payload
//   command  in         i_valid / o_ready   i_cmd, i_item_class, i_pet_id
//   result   out        o_valid / i_ready   o_status, o_out_pet_id, o_out_class
//
// every word passes two steps: accept (head entries read from both rings)
// then execute (stamp compare, ring update, result register load)
// one word in flight; a new word is taken only when the result register is
// empty or its word leaves in the same cycle
// a stalled result holds the block in idle with o_ready low
// reset is synchronous and clears the sequencer, pointers, counts and stamp
// counter; ring storage is left as is
// ----------------------------------------------------------------------------
module two_class_fifo_oldest_first (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [1:0]                i_cmd,
    input  logic                      i_item_class,
    input  logic [tcf_pkg::PID_W-1:0] i_pet_id,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [1:0]                o_status,
    output logic [tcf_pkg::PID_W-1:0] o_out_pet_id,
    output logic                      o_out_class
);
    import tcf_pkg::*;

    t_dp_cmd w_cmd;

    tcf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (w_cmd)
    );

    tcf_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_cmd_code   (i_cmd),
        .i_item_class (i_item_class),
        .i_pet_id     (i_pet_id),
        .o_status     (o_status),
        .o_out_pet_id (o_out_pet_id),
        .o_out_class  (o_out_class)
    );

endmodule

// File: verif/two_class_fifo_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_class_fifo_checker
// Watches the command and result channels of the two-class queue, keeps its
// own copy of both stamped rings and compares every result word in order.
// ----------------------------------------------------------------------------
module two_class_fifo_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cmd_valid,
    input  logic                      i_cmd_ready,
    input  logic [1:0]                i_cmd,
    input  logic                      i_item_class,
    input  logic [tcf_pkg::PID_W-1:0] i_pet_id,
    input  logic                      i_res_valid,
    input  logic                      i_res_ready,
    input  logic [1:0]                i_status,
    input  logic [tcf_pkg::PID_W-1:0] i_out_pet_id,
    input  logic                      i_out_class,
    output int                        o_fail_count,
    output int                        o_pending
);
    import tcf_pkg::*;

    typedef struct packed {
        logic [1:0]       status;
        logic [PID_W-1:0] pet_id;
        logic             item_class;
    } t_outcome;

    logic [STAMP_W-1:0] ring_stamp [2][QUEUE_DEPTH];
    logic [PID_W-1:0]   ring_pet   [2][QUEUE_DEPTH];
    int unsigned        ring_head  [2];
    int unsigned        ring_tail  [2];
    int unsigned        ring_count [2];
    logic [STAMP_W-1:0] stamp_counter;
    t_outcome           pending_outcomes [$];
    int                 fail_total = 0;

    initial o_fail_count = 0;
    initial o_pending    = 0;

    function automatic t_outcome pop_class(input logic cls);
        t_outcome r;
        r = '0;
        if (ring_count[cls] == 0) begin
            r.status = ST_EMPTY;
        end else begin
            r.status     = ST_OK;
            r.pet_id     = ring_pet[cls][ring_head[cls]];
            r.item_class = cls;
            ring_head[cls]  = (ring_head[cls] + 1) % QUEUE_DEPTH;
            ring_count[cls] = ring_count[cls] - 1;
        end
        return r;
    endfunction

    function automatic t_outcome queue_outcome(input logic [1:0] cmd, input logic cls,
                                               input logic [PID_W-1:0] pid);
        t_outcome r;
        r = '0;
        case (cmd)
            CMD_ENQ: begin
                if (ring_count[cls] >= QUEUE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    ring_stamp[cls][ring_tail[cls]] = stamp_counter;
                    ring_pet[cls][ring_tail[cls]]   = pid;
                    ring_tail[cls]  = (ring_tail[cls] + 1) % QUEUE_DEPTH;
                    ring_count[cls] = ring_count[cls] + 1;
                    stamp_counter   = stamp_counter + 1'b1;
                    r.status        = ST_OK;
                end
            end
            CMD_DEQ_ANY: begin
                // compare result picks the class: class 1 wins ties
                if (ring_count[1] != 0 && ring_count[0] != 0)
                    r = pop_class(ring_stamp[1][ring_head[1]] <= ring_stamp[0][ring_head[0]]);
                else if (ring_count[1] != 0)
                    r = pop_class(1'b1);
                else
                    r = pop_class(1'b0);
            end
            CMD_DEQ_C1: r = pop_class(1'b1);
            default:    r = pop_class(1'b0);
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            ring_head     = '{0, 0};
            ring_tail     = '{0, 0};
            ring_count    = '{0, 0};
            stamp_counter = '0;
            pending_outcomes.delete();
        end else begin
            // result first: it can never belong to a word taken this same edge
            if (i_res_valid && i_res_ready) begin
                if (pending_outcomes.size() == 0) begin
                    $error("result word with no command word pending");
                    fail_total++;
                end else begin
                    want = pending_outcomes.pop_front();
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, i_status);
                        fail_total++;
                    end
                    if (i_out_pet_id !== want.pet_id) begin
                        $error("out_pet_id: expected %h, actual %h", want.pet_id, i_out_pet_id);
                        fail_total++;
                    end
                    if (i_out_class !== want.item_class) begin
                        $error("out_class: expected %0d, actual %0d", want.item_class,
                               i_out_class);
                        fail_total++;
                    end
                end
            end
            if (i_cmd_valid && i_cmd_ready)
                pending_outcomes.push_back(queue_outcome(i_cmd, i_item_class, i_pet_id));
        end
        o_pending    <= pending_outcomes.size();
        o_fail_count <= fail_total;
    end

endmodule

// File: verif/two_class_fifo_oldest_first_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_class_fifo_oldest_first_test
// Drives directed and phased random command words into the two-class queue
// with bursty sending and a patterned result stall; the checker judges.
// ----------------------------------------------------------------------------
module two_class_fifo_oldest_first_test;
    import tcf_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_WORDS = 2000;
    localparam int DRAIN_CYCLES = 10;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BLOCKED} t_rx_mode;

    logic             i_clk        = 1'b0;
    logic             i_rst_n      = 1'b0;
    logic             i_valid      = 1'b0;
    logic [1:0]       i_cmd        = CMD_ENQ;
    logic             i_item_class = 1'b0;
    logic [PID_W-1:0] i_pet_id     = '0;
    logic             i_ready      = 1'b0;
    logic             o_ready;
    logic             o_valid;
    logic [1:0]       o_status;
    logic [PID_W-1:0] o_out_pet_id;
    logic             o_out_class;

    int       fail_count;
    int       pending_count;
    int       cycle_count = 0;
    int       burst_left  = 0;
    t_rx_mode rx_mode     = RX_OPEN;
    int       rx_left     = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    two_class_fifo_oldest_first uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_cmd        (i_cmd),
        .i_item_class (i_item_class),
        .i_pet_id     (i_pet_id),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_out_pet_id (o_out_pet_id),
        .o_out_class  (o_out_class)
    );

    two_class_fifo_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (i_valid),
        .i_cmd_ready  (o_ready),
        .i_cmd        (i_cmd),
        .i_item_class (i_item_class),
        .i_pet_id     (i_pet_id),
        .i_res_valid  (o_valid),
        .i_res_ready  (i_ready),
        .i_status     (o_status),
        .i_out_pet_id (o_out_pet_id),
        .i_out_class  (o_out_class),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side stalls on its own changing pattern
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 160);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:   i_ready <= 1'b1;
            RX_COIN:   i_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: i_ready <= ($urandom_range(0, 3) == 0);
            default:   i_ready <= (rx_left % 12 == 0);
        endcase
    end

    // present one word, hold it until taken, then maybe open a gap
    task automatic send_word(input logic [1:0] cmd, input logic cls,
                             input logic [PID_W-1:0] pid);
        int gap;
        @(negedge i_clk);
        i_valid      <= 1'b1;
        i_cmd        <= cmd;
        i_item_class <= cls;
        i_pet_id     <= pid;
        do @(posedge i_clk); while (!o_ready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    endtask

    initial begin
        int         phase_left;
        int         enq_pct;
        int         c1_pct;
        logic [1:0] cmd;
        logic       cls;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // pops on empty queues, class ignored on a dequeue
        send_word(CMD_DEQ_ANY, 1'b0, 32'h0000_0000);
        send_word(CMD_DEQ_C1,  1'b0, 32'hFFFF_FFFF);
        send_word(CMD_DEQ_C0,  1'b1, 32'hFFFF_FFFF);
        // interleaved stamps, oldest-first drains alternately
        send_word(CMD_ENQ,     1'b0, 32'h0000_0000);
        send_word(CMD_ENQ,     1'b1, 32'hFFFF_FFFF);
        send_word(CMD_ENQ,     1'b0, 32'hA5A5_A5A5);
        send_word(CMD_ENQ,     1'b1, 32'h5A5A_5A5A);
        send_word(CMD_DEQ_ANY, 1'b1, 32'h1234_5678);
        send_word(CMD_DEQ_ANY, 1'b0, 32'h0000_0000);
        send_word(CMD_DEQ_ANY, 1'b1, 32'h0000_0000);
        send_word(CMD_DEQ_ANY, 1'b0, 32'h0000_0000);
        send_word(CMD_DEQ_ANY, 1'b0, 32'h0000_0000);
        // named pop skips an older head in the other class
        send_word(CMD_ENQ,     1'b1, 32'h8000_0001);
        send_word(CMD_ENQ,     1'b0, 32'h7FFF_FFFE);
        send_word(CMD_DEQ_C0,  1'b1, 32'h0000_0000);
        // one queue empty: oldest-first takes the other
        send_word(CMD_DEQ_ANY, 1'b0, 32'h0000_0000);
        send_word(CMD_ENQ,     1'b0, 32'hDEAD_BEEF);
        send_word(CMD_DEQ_ANY, 1'b1, 32'h0000_0000);
        send_word(CMD_DEQ_C1,  1'b0, 32'h0000_0000);

        // phases lean toward filling or draining so full and empty both occur
        phase_left = 0;
        enq_pct    = 50;
        c1_pct     = 50;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(8, 48);
                case ($urandom_range(0, 3))
                    0:       enq_pct = 90;
                    1:       enq_pct = 15;
                    default: enq_pct = 50;
                endcase
                c1_pct = $urandom_range(0, 2) * 40 + 10;
            end
            phase_left--;
            cls = ($urandom_range(0, 99) < c1_pct);
            if ($urandom_range(0, 99) < enq_pct) begin
                cmd = CMD_ENQ;
            end else begin
                case ($urandom_range(0, 2))
                    0:       cmd = CMD_DEQ_ANY;
                    1:       cmd = CMD_DEQ_C1;
                    default: cmd = CMD_DEQ_C0;
                endcase
            end
            send_word(cmd, cls, $urandom());
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0 && pending_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            if (pending_count != 0)
                $error("%0d result words never arrived", pending_count);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
